>>> hdl/dst_pkg.sv
// Shared types, codes and helper functions for the depth/stencil test block.
// Used by dst_test_core and depth_stencil_test; depends on nothing else.
package dst_pkg;

    // Default geometry of the depth and stencil stores.
    localparam int DEF_FB_WIDTH    = 64;
    localparam int DEF_FB_HEIGHT   = 64;
    localparam int DEF_SAMPLES_PER_PIXEL = 4;

    // Stream payload widths.
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // Item commands.
    localparam logic [1:0] CMD_TEST          = 2'd0;
    localparam logic [1:0] CMD_CLEAR_DEPTH   = 2'd1;
    localparam logic [1:0] CMD_CLEAR_STENCIL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CONTROL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_EN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_CONTROL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_CONTROL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_MASK       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_MASK      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STENCIL_REF     = 3'd6;

    localparam logic [7:0] STENCIL_MAX = 8'hFF;

    // Comparison functions.
    localparam logic [2:0] FUNC_NEVER         = 3'd0;
    localparam logic [2:0] FUNC_LESS          = 3'd1;
    localparam logic [2:0] FUNC_EQUAL         = 3'd2;
    localparam logic [2:0] FUNC_LESS_EQUAL    = 3'd3;
    localparam logic [2:0] FUNC_GREATER       = 3'd4;
    localparam logic [2:0] FUNC_NOT_EQUAL     = 3'd5;
    localparam logic [2:0] FUNC_GREATER_EQUAL = 3'd6;
    localparam logic [2:0] FUNC_ALWAYS        = 3'd7;

    // Stencil operations.
    localparam logic [2:0] OP_KEEP      = 3'd0;
    localparam logic [2:0] OP_ZERO      = 3'd1;
    localparam logic [2:0] OP_REPLACE   = 3'd2;
    localparam logic [2:0] OP_INCR_SAT  = 3'd3;
    localparam logic [2:0] OP_DECR_SAT  = 3'd4;
    localparam logic [2:0] OP_INVERT    = 3'd5;
    localparam logic [2:0] OP_INCR_WRAP = 3'd6;
    localparam logic [2:0] OP_DECR_WRAP = 3'd7;

    typedef struct packed {
        logic [4:0]  depth_control;
        logic        stencil_en;
        logic [11:0] front_control;
        logic [11:0] back_control;
        logic [7:0]  read_mask;
        logic [7:0]  write_mask;
        logic [7:0]  reference;
    } dst_cfg_t;

    typedef struct packed {
        logic       color_write;
        logic       depth_ok;
        logic       stencil_ok;
        logic [7:0] stencil_result;
        logic       depth_we;
        logic       stencil_we;
    } dst_result_t;

    function automatic logic dst_compare(input logic [2:0] func,
                                         input logic [23:0] a,
                                         input logic [23:0] b);
        logic r;
        case (func)
            FUNC_NEVER:         r = 1'b0;
            FUNC_LESS:          r = a < b;
            FUNC_EQUAL:         r = a == b;
            FUNC_LESS_EQUAL:    r = a <= b;
            FUNC_GREATER:       r = a > b;
            FUNC_NOT_EQUAL:     r = a != b;
            FUNC_GREATER_EQUAL: r = a >= b;
            FUNC_ALWAYS:        r = 1'b1;
            default:            r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/dst_test_core.sv
// Depth compare, stencil compare and stencil update for one sample.
// Purely combinational; depends on dst_pkg.
module dst_test_core (
    input  dst_pkg::dst_cfg_t    cfg,
    input  logic                 front_facing,
    input  logic [23:0]          frag_depth,
    input  logic [23:0]          stored_depth,
    input  logic [7:0]           stored_stencil,
    output dst_pkg::dst_result_t res
);
    import dst_pkg::*;

    logic        d_en;
    logic        d_wr;
    logic        dp;
    logic        sp;
    logic [11:0] ctl;
    logic [2:0]  op;
    logic [7:0]  val;
    logic [7:0]  new_s;

    assign d_en = cfg.depth_control[0];
    assign d_wr = cfg.depth_control[1];
    assign ctl  = front_facing ? cfg.front_control : cfg.back_control;
    assign dp   = d_en ? dst_compare(cfg.depth_control[4:2], frag_depth, stored_depth) : 1'b1;

    always_comb begin
        sp    = 1'b1;
        op    = OP_KEEP;
        val   = stored_stencil;
        new_s = stored_stencil;
        if (cfg.stencil_en) begin
            sp = dst_compare(ctl[2:0], {16'd0, cfg.reference & cfg.read_mask},
                             {16'd0, stored_stencil & cfg.read_mask});
            // Fail op wins over depth-fail op, which wins over pass op.
            if (!sp) begin
                op = ctl[5:3];
            end else if (!dp) begin
                op = ctl[11:9];
            end else begin
                op = ctl[8:6];
            end
            case (op)
                OP_KEEP:      val = stored_stencil;
                OP_ZERO:      val = 8'd0;
                OP_REPLACE:   val = cfg.reference;
                OP_INCR_SAT:  val = (stored_stencil == STENCIL_MAX) ? STENCIL_MAX
                                                                    : stored_stencil + 8'd1;
                OP_DECR_SAT:  val = (stored_stencil == 8'd0) ? 8'd0 : stored_stencil - 8'd1;
                OP_INVERT:    val = ~stored_stencil;
                OP_INCR_WRAP: val = stored_stencil + 8'd1;
                OP_DECR_WRAP: val = stored_stencil - 8'd1;
                default:      val = stored_stencil;
            endcase
            new_s = (stored_stencil & ~cfg.write_mask) | (val & cfg.write_mask);
        end
    end

    assign res.color_write    = dp && sp;
    assign res.depth_ok       = dp;
    assign res.stencil_ok     = sp;
    assign res.stencil_result = new_s;
    assign res.depth_we       = dp && sp && d_en && d_wr;
    assign res.stencil_we     = cfg.stencil_en;

endmodule

>>> hdl/depth_stencil_test.sv
// Depth/stencil test block: configuration registers, depth and stencil stores,
// a two-stage read-modify-write pipeline and the result register.
// Depends on dst_pkg and dst_test_core.
//
// Usage:
//   Items enter on the s_ stream (command in s_tuser, sample fields in s_tdata)
//   and each item leaves exactly one transaction on the m_ stream. A test
//   item reports the depth and stencil outcomes and the updated stencil;
//   clear items and items outside the framebuffer return all zeros.
//   The user must write configuration (cfg_valid/cfg_ready/cfg_index/cfg_data)
//   only while idle; the block does not enforce it. cfg_ready is always high.
//   Throughput is one item per cycle unless the output stalls: the stores
//   are read at acceptance, written back when the second stage advances,
//   and a read of the entry being written that same edge takes the forwarded
//   value. m_tvalid rises once the second stage finishes. When m_tready is
//   low with m_tvalid high, the result register holds, a second-stage item
//   waits with its read data and s_tready drops until the result moves on.
//   Reset clears the control state and loads the register defaults; store
//   contents are undefined until a clear or test transaction writes them.
module depth_stencil_test #(
    parameter int FB_WIDTH    = dst_pkg::DEF_FB_WIDTH,
    parameter int FB_HEIGHT   = dst_pkg::DEF_FB_HEIGHT,
    parameter int SAMPLES_PER_PIXEL = dst_pkg::DEF_SAMPLES_PER_PIXEL
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: pos_x[5:0], pos_y[11:6], sample_index[13:12], frag_depth[37:14],
    // front_facing[38], clear_stencil_value[46:39], zero[47]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dst_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: command[1:0]
    input  logic [dst_pkg::S_TUSER_W-1:0]   s_tuser,
    // m_tdata: color_write[0], depth_ok[1], stencil_ok[2],
    // stencil_result[10:3], zero[15:11]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dst_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dst_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dst_pkg::*;

    localparam int STORE_SIZE = FB_WIDTH * FB_HEIGHT * SAMPLES_PER_PIXEL;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    // Configuration registers.
    logic [4:0]  depth_control_reg;
    logic        stencil_en_reg;
    logic [11:0] front_control_reg;
    logic [11:0] back_control_reg;
    logic [7:0]  read_mask_reg;
    logic [7:0]  write_mask_reg;
    logic [7:0]  reference_reg;
    dst_cfg_t    cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_control_reg  <= '0;
            stencil_en_reg     <= 1'b0;
            front_control_reg  <= '0;
            back_control_reg   <= '0;
            read_mask_reg      <= STENCIL_MAX;
            write_mask_reg     <= STENCIL_MAX;
            reference_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEPTH_CONTROL:  depth_control_reg  <= cfg_data[4:0];
                REG_STENCIL_EN:     stencil_en_reg     <= cfg_data[0];
                REG_FRONT_CONTROL:  front_control_reg  <= cfg_data;
                REG_BACK_CONTROL:   back_control_reg   <= cfg_data;
                REG_READ_MASK:      read_mask_reg      <= cfg_data[7:0];
                REG_WRITE_MASK:     write_mask_reg     <= cfg_data[7:0];
                REG_STENCIL_REF:    reference_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg.depth_control  = depth_control_reg;
    assign cfg.stencil_en     = stencil_en_reg;
    assign cfg.front_control  = front_control_reg;
    assign cfg.back_control   = back_control_reg;
    assign cfg.read_mask      = read_mask_reg;
    assign cfg.write_mask     = write_mask_reg;
    assign cfg.reference      = reference_reg;

    // Input field unpacking and address generation.
    logic [5:0]        in_x;
    logic [5:0]        in_y;
    logic [1:0]        in_s;
    logic [23:0]       in_depth;
    logic              in_front;
    logic [7:0]        in_clr_st;
    logic              in_range;
    logic [31:0]       idx_full;
    logic [ADDR_W-1:0] rd_idx;

    assign in_x      = s_tdata[5:0];
    assign in_y      = s_tdata[11:6];
    assign in_s      = s_tdata[13:12];
    assign in_depth  = s_tdata[37:14];
    assign in_front  = s_tdata[38];
    assign in_clr_st = s_tdata[46:39];

    assign in_range = (32'(in_x) < 32'(FB_WIDTH)) && (32'(in_y) < 32'(FB_HEIGHT)) &&
                      (32'(in_s) < 32'(SAMPLES_PER_PIXEL));
    assign idx_full = (32'(in_y) * 32'(FB_WIDTH) + 32'(in_x)) * 32'(SAMPLES_PER_PIXEL) +
                      32'(in_s);
    assign rd_idx   = idx_full[ADDR_W-1:0];

    // Pipeline control.
    logic busy_reg;
    logic m_tvalid_reg;
    logic adv;
    logic accept;

    assign adv      = busy_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !busy_reg || adv;
    assign accept   = s_tvalid && s_tready;

    // Second-stage item registers.
    logic [1:0]        cmd_reg;
    logic              range_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [23:0]       depth_reg;
    logic              front_reg;
    logic [7:0]        clr_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (adv) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_tuser;
            range_reg  <= in_range;
            idx_reg    <= rd_idx;
            depth_reg  <= in_depth;
            front_reg  <= in_front;
            clr_st_reg <= in_clr_st;
        end
    end

    // Stores with synchronous read and write-back forwarding.
    logic [23:0] depth_mem [STORE_SIZE];
    logic [7:0]  stencil_mem [STORE_SIZE];
    logic [23:0] depth_rd_reg;
    logic [7:0]  stencil_rd_reg;
    logic        d_fwd_reg;
    logic        s_fwd_reg;
    logic [23:0] d_fwd_data_reg;
    logic [7:0]  s_fwd_data_reg;
    logic        d_we;
    logic        s_we;
    logic [23:0] d_wdata;
    logic [7:0]  s_wdata;
    logic [23:0] stored_depth;
    logic [7:0]  stored_stencil;
    dst_result_t res;

    assign stored_depth   = d_fwd_reg ? d_fwd_data_reg : depth_rd_reg;
    assign stored_stencil = s_fwd_reg ? s_fwd_data_reg : stencil_rd_reg;

    dst_test_core u_core (
        .cfg            (cfg),
        .front_facing   (front_reg),
        .frag_depth     (depth_reg),
        .stored_depth   (stored_depth),
        .stored_stencil (stored_stencil),
        .res            (res)
    );

    assign d_we = adv && range_reg &&
                  ((cmd_reg == CMD_CLEAR_DEPTH) || ((cmd_reg == CMD_TEST) && res.depth_we));
    assign s_we = adv && range_reg &&
                  ((cmd_reg == CMD_CLEAR_STENCIL) || ((cmd_reg == CMD_TEST) && res.stencil_we));
    assign d_wdata = depth_reg;
    assign s_wdata = (cmd_reg == CMD_CLEAR_STENCIL) ? clr_st_reg : res.stencil_result;

    always_ff @(posedge aclk) begin
        if (d_we) begin
            depth_mem[idx_reg] <= d_wdata;
        end
        if (accept) begin
            depth_rd_reg <= depth_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_we) begin
            stencil_mem[idx_reg] <= s_wdata;
        end
        if (accept) begin
            stencil_rd_reg <= stencil_mem[rd_idx];
        end
    end

    // A read that meets a write to the same entry takes the new value.
    always_ff @(posedge aclk) begin
        if (accept) begin
            d_fwd_reg      <= d_we && (idx_reg == rd_idx);
            s_fwd_reg      <= s_we && (idx_reg == rd_idx);
            d_fwd_data_reg <= d_wdata;
            s_fwd_data_reg <= s_wdata;
        end
    end

    // Result register.
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    always_comb begin
        m_tdata_next = '0;
        if (range_reg && (cmd_reg == CMD_TEST)) begin
            m_tdata_next[0]    = res.color_write;
            m_tdata_next[1]    = res.depth_ok;
            m_tdata_next[2]    = res.stencil_ok;
            m_tdata_next[10:3] = res.stencil_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks.
    a_adv_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_tvalid_reg)
        else $error("finished item did not reach the result register");

    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !adv) |=> (busy_reg && $stable(idx_reg) && $stable(cmd_reg)))
        else $error("stalled item changed in the second stage");

    a_depth_write_on_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (d_we && (cmd_reg == CMD_TEST)) |-> res.color_write)
        else $error("depth written by a test that did not pass");

    a_color_implies_both: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (!m_tdata_reg[0] || (m_tdata_reg[1] && m_tdata_reg[2])))
        else $error("color write reported without both tests passing");

    a_no_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (!d_we && !s_we))
        else $error("store written with no item in the second stage");

endmodule
